// File: sv/best_fit_arena_allocator_core_defines.svh
// Assertion macros for the best-fit arena allocator.
// Included by files that check their own logic; expects clk and rst in scope.
`ifndef BEST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_ARENA_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, gated off during reset
`define BFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa: same-cycle check failed");

// Next-cycle implication, gated off during reset
`define BFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa: next-cycle check failed");

`endif

// File: sv/bfa_pkg.sv
// Shared types and constants of the best-fit arena allocator.
// No dependencies; the design and bench files use it, the defines header does not.
`default_nettype none

package bfa_pkg;

  // Default table depth
  localparam int unsigned MaxEntriesDefault = 256;

  // Layout constants
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned AlignBytes  = 16;
  localparam int unsigned PageBytes   = 4096;

  // Field and datapath widths
  localparam int unsigned ReqW  = 24;
  localparam int unsigned OffW  = 24;
  localparam int unsigned SizeW = 25;
  localparam int unsigned CapW  = 25;
  localparam int unsigned CalcW = 27;  // holds used + need rounded to a page
  localparam int unsigned DivW  = 17;  // holds the largest page size
  localparam int unsigned StatW = 2;

  localparam logic [CapW-1:0] CapacityReset = CapW'(16777216);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [StatW-1:0] ST_GRANTED = 2'd0;
  localparam logic [StatW-1:0] ST_REFUSED = 2'd1;
  localparam logic [StatW-1:0] ST_FREED   = 2'd2;
  localparam logic [StatW-1:0] ST_IGNORED = 2'd3;

  // One table entry
  typedef struct packed {
    logic             free;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  start;
  } entry_t;

  // Round-up unit handshake
  typedef struct packed {
    logic             start;
    logic [CalcW-1:0] value;
    logic [DivW-1:0]  divisor;
  } rnd_req_t;

  typedef struct packed {
    logic             done;
    logic [CalcW-1:0] result;
  } rnd_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NEED_WAIT,
    S_SCAN,
    S_REUSE,
    S_FIT_CHK,
    S_FIT_CMP,
    S_FLOOR_WAIT,
    S_GROW_MAX,
    S_GROW_CHK,
    S_APPEND,
    S_FREE_SCAN,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

// File: sv/bfa_if.sv
// Request and response channel interfaces of the best-fit arena allocator.
// Depends on bfa_pkg for field widths.
`default_nettype none

interface bfa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [bfa_pkg::ReqW-1:0]   request_bytes;
  logic [bfa_pkg::OffW-1:0]   user_offset;

  modport source (output valid, operation, request_bytes, user_offset, input ready);
  modport sink   (input valid, operation, request_bytes, user_offset, output ready);
endinterface

interface bfa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::StatW-1:0]   status;
  logic [bfa_pkg::OffW-1:0]    granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

`default_nettype wire

// File: sv/bfa_round_unit.sv
// Shared round-up unit: value rounded up to a multiple of a power-of-two divisor.
// Add divisor - 1 and clear the low bits; depends on bfa_pkg.
`default_nettype none

module bfa_round_unit (
  input  logic              clk,
  input  logic              rst,
  input  bfa_pkg::rnd_req_t rq,
  output bfa_pkg::rnd_rsp_t rs
);
  import bfa_pkg::*;

  logic [CalcW-1:0] low_mask;
  logic [CalcW-1:0] result;
  logic             done;

  // Divisor is a power of two: divisor - 1 masks the remainder bits
  assign low_mask = CalcW'(rq.divisor) - CalcW'(1);

  assign rs.done   = done;
  assign rs.result = result;

  // Done pulses the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rq.start;
    end
  end

  // Add and mask
  always_ff @(posedge clk) begin
    if (rq.start) begin
      result <= (rq.value + low_mask) & ~low_mask;
    end
  end

endmodule

`default_nettype wire

// File: sv/bfa_table.sv
// Block table memory: one write port, one read port with registered data.
// Depends on bfa_pkg for the entry type.
`default_nettype none

module bfa_table #(
  parameter int unsigned DEPTH = bfa_pkg::MaxEntriesDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bfa_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output bfa_pkg::entry_t rdata
);
  import bfa_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/best_fit_arena_allocator_core.sv
// Best-fit arena allocator top level: sequencer, table scan and growth logic.
// Depends on bfa_pkg, bfa_if, bfa_table, bfa_round_unit and the defines header.
//
//  Channel | Dir | Words                     | Handshake
//  --------+-----+---------------------------+--------------------------
//  req     | in  | operation, request, offset| valid/ready
//  rsp     | out | status, granted offset    | valid/ready
//  cfg     | in  | arena capacity            | cfg_we, no wait
//
// One word at a time. A free scans the table with one table read per cycle
// through the single read port and replies once an offset matches or the
// scan ends. An allocation scans the whole table, then reuses the best free
// block, appends one (growing the arena first if needed) or is refused; each
// round-up runs in the shared add-and-mask unit. The input is ready again once the reply word loads.
// Reset is synchronous and empties the table at once through the entry count.
// A pending response does not block the next request; a finished one waits.
`default_nettype none

module best_fit_arena_allocator_core #(
  parameter int unsigned MAX_ENTRIES = bfa_pkg::MaxEntriesDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CapW-1:0]  cfg_data,
  bfa_req_if.sink                   req,
  bfa_rsp_if.source                 rsp
);
  import bfa_pkg::*;

  `include "best_fit_arena_allocator_core_defines.svh"

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  state_t           state, state_next;
  logic [CapW-1:0]  capacity;
  logic [CntW-1:0]  entry_count;
  logic [SizeW-1:0] used_bytes;
  logic [SizeW-1:0] committed_bytes;

  logic [OffW-1:0]  uoff_q;
  logic [SizeW-1:0] need;
  logic [CntW-1:0]  scan_idx;
  logic             chk_valid;
  logic [AW-1:0]    chk_idx;
  logic             found;
  logic [AW-1:0]    best_idx;
  logic [SizeW-1:0] best_size;
  logic [OffW-1:0]  best_start;
  logic [CalcW-1:0] sum_q;
  logic [CalcW-1:0] floor_q;
  logic [CalcW-1:0] target_q;
  logic [StatW-1:0] res_status;
  logic [OffW-1:0]  res_offset;

  logic             out_valid;
  logic [StatW-1:0] out_status;
  logic [OffW-1:0]  out_offset;

  logic             accept;
  logic             issuing;
  logic             scan_hit;
  logic             free_match;
  logic             load_out;
  logic [CalcW-1:0] grow_base;

  rnd_req_t         rq;
  rnd_rsp_t         rs;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_rdata;

  bfa_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfa_round_unit u_round (
    .clk (clk),
    .rst (rst),
    .rq  (rq),
    .rs  (rs)
  );

  // Scan helpers: issue side and compare side of the read pipeline
  assign accept   = req.valid && req.ready;
  assign issuing  = scan_idx < entry_count;
  assign scan_hit = chk_valid && mem_rdata.free && (mem_rdata.size >= need) &&
                    (!found || (mem_rdata.size < best_size));
  assign free_match = chk_valid &&
                      ((mem_rdata.start + OffW'(HeaderBytes)) == uoff_q);
  assign load_out = (state == S_RESULT) && (!out_valid || rsp.ready);

  // Growth base: one page from empty, else double
  assign grow_base = (committed_bytes == '0) ? CalcW'(PageBytes)
                                             : {1'b0, committed_bytes, 1'b0};

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_offset = out_offset;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    rq.start    = 1'b0;
    rq.value    = CalcW'(req.request_bytes) + CalcW'(HeaderBytes);
    rq.divisor  = DivW'(AlignBytes);
    mem_we      = 1'b0;
    mem_waddr   = chk_idx;
    mem_wdata   = '{free: 1'b1, size: mem_rdata.size, start: mem_rdata.start};
    mem_raddr   = scan_idx[AW-1:0];
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.operation == OP_FREE) begin
            state_next = S_FREE_SCAN;
          end else if (req.request_bytes == '0) begin
            state_next = S_RESULT;
          end else begin
            rq.start   = 1'b1;
            state_next = S_NEED_WAIT;
          end
        end
      end
      S_NEED_WAIT: begin
        if (rs.done) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!issuing && !chk_valid) begin
          state_next = found ? S_REUSE : S_FIT_CHK;
        end
      end
      S_REUSE: begin
        mem_we     = 1'b1;
        mem_waddr  = best_idx;
        mem_wdata  = '{free: 1'b0, size: best_size, start: best_start};
        state_next = S_RESULT;
      end
      S_FIT_CHK: begin
        state_next = (entry_count == CntW'(MAX_ENTRIES)) ? S_RESULT : S_FIT_CMP;
      end
      S_FIT_CMP: begin
        if (sum_q <= CalcW'(committed_bytes)) begin
          state_next = S_APPEND;
        end else begin
          rq.start   = 1'b1;
          rq.value   = sum_q;
          rq.divisor = DivW'(PageBytes);
          state_next = S_FLOOR_WAIT;
        end
      end
      S_FLOOR_WAIT: begin
        if (rs.done) state_next = S_GROW_MAX;
      end
      S_GROW_MAX: state_next = S_GROW_CHK;
      S_GROW_CHK: begin
        state_next = (target_q > CalcW'(capacity)) ? S_RESULT : S_APPEND;
      end
      S_APPEND: begin
        mem_we     = 1'b1;
        mem_waddr  = entry_count[AW-1:0];
        mem_wdata  = '{free: 1'b0, size: need, start: used_bytes[OffW-1:0]};
        state_next = S_RESULT;
      end
      S_FREE_SCAN: begin
        if (free_match) begin
          mem_we     = !mem_rdata.free;
          state_next = S_RESULT;
        end else if (!issuing && !chk_valid) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Arena bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= CapacityReset;
      entry_count     <= '0;
      used_bytes      <= '0;
      committed_bytes <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (state == S_GROW_CHK && target_q <= CalcW'(capacity)) begin
        committed_bytes <= target_q[SizeW-1:0];
      end
      if (state == S_APPEND) begin
        entry_count <= entry_count + 1'b1;
        used_bytes  <= sum_q[SizeW-1:0];
      end
    end
  end

  // Scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
      found     <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if (state == S_SCAN || state == S_FREE_SCAN) begin
        chk_valid <= issuing;
        if (issuing) scan_idx <= scan_idx + 1'b1;
        if (state == S_SCAN && scan_hit) found <= 1'b1;
      end else begin
        chk_valid <= 1'b0;
        scan_idx  <= '0;
        found     <= 1'b0;
      end
    end
  end

  // Request datapath and result staging
  always_ff @(posedge clk) begin
    chk_idx <= scan_idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          uoff_q     <= req.user_offset;
          res_status <= (req.operation == OP_FREE) ? ST_IGNORED : ST_REFUSED;
          res_offset <= '0;
        end
      end
      S_NEED_WAIT: begin
        if (rs.done) need <= rs.result[SizeW-1:0];
      end
      S_SCAN: begin
        if (scan_hit) begin
          best_idx   <= chk_idx;
          best_size  <= mem_rdata.size;
          best_start <= mem_rdata.start;
        end
      end
      S_REUSE: begin
        res_status <= ST_GRANTED;
        res_offset <= best_start + OffW'(HeaderBytes);
      end
      S_FIT_CHK: begin
        sum_q <= CalcW'(used_bytes) + CalcW'(need);
      end
      S_FLOOR_WAIT: begin
        if (rs.done) floor_q <= rs.result;
      end
      S_GROW_MAX: begin
        target_q <= (floor_q > grow_base) ? floor_q : grow_base;
      end
      S_APPEND: begin
        res_status <= ST_GRANTED;
        res_offset <= used_bytes[OffW-1:0] + OffW'(HeaderBytes);
      end
      S_FREE_SCAN: begin
        if (free_match && !mem_rdata.free) res_status <= ST_FREED;
      end
      default: begin
      end
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  // Checks on the bookkeeping and the sequencer
  `BFA_ASSERT_IMP(a_count_bound, 1'b1, entry_count <= CntW'(MAX_ENTRIES))
  `BFA_ASSERT_IMP(a_used_in_commit, 1'b1, used_bytes <= committed_bytes)
  `BFA_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
  `BFA_ASSERT_IMP(a_offset_zero, rsp.valid && rsp.status != ST_GRANTED, rsp.granted_offset == '0)

endmodule

`default_nettype wire

// File: bench/best_fit_arena_allocator_core_test.sv
// Self-checking bench for best_fit_arena_allocator_core: drives requests, predicts replies.
// Depends on bfa_pkg and the bfa_req_if / bfa_rsp_if channel interfaces.
// Arena state is tracked word by word; capacity moves through several settings.
module best_fit_arena_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int unsigned TableDepth = MaxEntriesDefault;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned LongHold   = 3000;
  localparam int unsigned MaxReports = 10;

  localparam logic [CapW-1:0] CapTight = CapW'(20000);
  localparam logic [CapW-1:0] CapNone  = '0;
  localparam logic [CapW-1:0] CapMax   = '1;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [OffW-1:0]  offset;
  } reply_t;

  // Arena bookkeeping plus the queue of replies still owed by the block
  class arena_ledger;
    bit [OffW-1:0]  blk_start [TableDepth];
    bit [SizeW-1:0] blk_size  [TableDepth];
    bit             blk_free  [TableDepth];
    int unsigned    blk_count;
    bit [SizeW-1:0] used;
    bit [CapW-1:0]  committed;
    bit [CapW-1:0]  capacity;
    reply_t         expected_replies[$];
    bit [OffW-1:0]  handed_out[$];
    int unsigned    errors;

    function new();
      blk_count = 0;
      used      = '0;
      committed = '0;
      capacity  = CapacityReset;
      errors    = 0;
    endfunction

    function automatic longint unsigned align_up(longint unsigned x, longint unsigned a);
      return ((x + a - 1) / a) * a;
    endfunction

    // Commit more arena if the append does not fit; 0 means over capacity
    function automatic bit try_grow(longint unsigned need);
      longint unsigned sum;
      longint unsigned target;
      longint unsigned floor_sz;
      sum = used;
      sum += need;
      if (sum <= committed) return 1'b1;
      target   = (committed == 0) ? PageBytes : 2 * longint'(committed);
      target   = align_up(target, PageBytes);
      floor_sz = align_up(sum, PageBytes);
      if (floor_sz > target) target = floor_sz;
      if (target > capacity) return 1'b0;
      committed = CapW'(target);
      return 1'b1;
    endfunction

    // Apply one request to the arena and return the reply it earns
    function automatic reply_t resolve_request(logic op, logic [ReqW-1:0] bytes,
                                               logic [OffW-1:0] offset);
      reply_t          r;
      longint unsigned need;
      bit              found;
      int unsigned     best;
      r.status = ST_REFUSED;
      r.offset = '0;
      if (op == OP_ALLOC) begin
        if (bytes == 0) return r;
        need  = align_up(longint'(bytes) + HeaderBytes, AlignBytes);
        found = 1'b0;
        best  = 0;
        // best fit, lowest entry on a tie
        for (int unsigned i = 0; i < blk_count; i++) begin
          if (blk_free[i] && blk_size[i] >= need && (!found || blk_size[i] < blk_size[best])) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (found) begin
          blk_free[best] = 1'b0;
          r.status = ST_GRANTED;
          r.offset = OffW'(blk_start[best] + HeaderBytes);
          return r;
        end
        if (blk_count >= TableDepth) return r;
        if (!try_grow(need)) return r;
        blk_start[blk_count] = OffW'(used);
        blk_size[blk_count]  = SizeW'(need);
        blk_free[blk_count]  = 1'b0;
        r.status = ST_GRANTED;
        r.offset = OffW'(blk_start[blk_count] + HeaderBytes);
        blk_count++;
        used = SizeW'(longint'(used) + need);
      end else begin
        r.status = ST_IGNORED;
        // first block whose wrapped user offset matches decides
        for (int unsigned i = 0; i < blk_count; i++) begin
          if (OffW'(blk_start[i] + HeaderBytes) == offset) begin
            if (!blk_free[i]) begin
              blk_free[i] = 1'b1;
              r.status = ST_FREED;
            end
            break;
          end
        end
      end
      return r;
    endfunction

    function automatic void note_request(logic op, logic [ReqW-1:0] bytes,
                                         logic [OffW-1:0] offset);
      reply_t r;
      r = resolve_request(op, bytes, offset);
      if (r.status == ST_GRANTED) handed_out.push_back(r.offset);
      expected_replies.push_back(r);
    endfunction

    function automatic void check_reply(logic [StatW-1:0] status, logic [OffW-1:0] offset);
      reply_t exp;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("[%0t] unexpected reply: status %0d offset %h", $realtime, status, offset);
        return;
      end
      exp = expected_replies.pop_front();
      if (exp.status !== status || exp.offset !== offset) begin
        errors++;
        if (errors <= MaxReports)
          $display("[%0t] reply mismatch: status exp %0d got %0d, offset exp %h got %h",
                   $realtime, exp.status, status, exp.offset, offset);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic [CapW-1:0] cfg_data;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  arena_ledger ledger = new();

  int unsigned burst_left = 0;
  bit          hold_off_request = 1'b0;
  int unsigned cycle_count;

  best_fit_arena_allocator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word in a burst/gap pattern and log it once accepted
  task automatic offer_request(input logic op, input logic [ReqW-1:0] bytes,
                               input logic [OffW-1:0] offset);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.request_bytes <= bytes;
    req_ch.user_offset   <= offset;
    do @(posedge clk); while (!req_ch.ready);
    ledger.note_request(op, bytes, offset);
    burst_left--;
  endtask

  task automatic ask_alloc(input logic [ReqW-1:0] bytes);
    offer_request(OP_ALLOC, bytes, OffW'($urandom));
  endtask

  task automatic ask_free(input logic [OffW-1:0] offset);
    offer_request(OP_FREE, ReqW'($urandom), offset);
  endtask

  // Stop offering and wait for every owed reply
  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (ledger.expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.capacity = value;
  endtask

  // Mostly small sizes, a few huge ones, the odd zero
  function automatic logic [ReqW-1:0] pick_size(int unsigned big_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < big_pct) return ReqW'($urandom_range(1 << 20, (1 << 24) - 1));
    if (r < big_pct + 2) return '0;
    if (r < big_pct + 12) return ReqW'($urandom_range(1, 16));
    return ReqW'($urandom_range(1, 700));
  endfunction

  // Live-looking offsets most of the time, near misses and noise otherwise
  function automatic logic [OffW-1:0] pick_free_offset();
    int unsigned   r;
    logic [OffW-1:0] o;
    r = $urandom_range(0, 99);
    if (ledger.handed_out.size() == 0 || r < 10) return OffW'($urandom);
    o = ledger.handed_out[$urandom_range(0, ledger.handed_out.size() - 1)];
    if (r < 20) o = o + OffW'(AlignBytes);
    return o;
  endfunction

  task automatic mixed_traffic(input int unsigned n, input int unsigned free_pct,
                               input int unsigned big_pct);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < free_pct) ask_free(pick_free_offset());
      else ask_alloc(pick_size(big_pct));
    end
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int unsigned stretch_left;
    int unsigned hold_left;
    int unsigned r;
    bit          stretch_ready;
    stretch_left  = 0;
    hold_left     = 0;
    stretch_ready = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        ledger.check_reply(rsp_ch.status, rsp_ch.granted_offset);
      if (hold_left == 0 && hold_off_request) begin
        hold_left = LongHold;
        hold_off_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            stretch_ready = 1'b1;
            stretch_left  = $urandom_range(50, 300);
          end else if (r < 7) begin
            stretch_ready = 1'b1;
            stretch_left  = $urandom_range(1, 6);
          end else begin
            stretch_ready = 1'b0;
            stretch_left  = $urandom_range(1, 20);
          end
        end
        stretch_left--;
        rsp_ch.ready <= stretch_ready;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("best_fit_arena_allocator_core_test: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned tries;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_data             <= CapacityReset;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_ALLOC;
    req_ch.request_bytes <= '0;
    req_ch.user_offset   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset capacity, layout known from an empty arena
    write_capacity(CapacityReset);
    ask_alloc('0);                 // zero request
    ask_alloc(ReqW'(1));           // first block, commits one page, offset 24
    ask_free(OffW'(24));
    ask_free(OffW'(24));           // double free
    ask_free('0);                  // unknown offset
    ask_free('1);
    ask_alloc(ReqW'(8));           // reuses the freed block
    ask_alloc(ReqW'(100));         // 128-byte block, user offset 56
    ask_alloc(ReqW'(100));         // 128-byte block, user offset 184
    ask_alloc(ReqW'(40));          // 64-byte block, user offset 312
    ask_alloc(ReqW'(200));
    ask_free(OffW'(56));
    ask_free(OffW'(184));
    ask_free(OffW'(312));
    ask_alloc(ReqW'(30));          // best fit takes the 64-byte block
    ask_alloc(ReqW'(90));          // tie between the 128s, lowest entry wins
    ask_alloc('1);                 // largest request, past capacity
    ask_alloc(ReqW'(4000));        // growth past one page
    ask_alloc(ReqW'(8000));
    ask_free(OffW'(184));

    // Tight capacity, growth gets refused
    write_capacity(CapTight);
    mixed_traffic(70, 30, 2);

    // No capacity: only reuse and already committed room
    write_capacity(CapNone);
    mixed_traffic(25, 40, 0);

    // Full 25-bit capacity: huge block pushes later starts past the 24-bit wrap
    write_capacity(CapMax);
    ask_alloc('1);
    hold_off_request = 1'b1;
    tries = 0;
    while (ledger.blk_count < TableDepth && tries < 320) begin
      ask_alloc(pick_size(3));
      tries++;
    end
    // table full: allocs either reuse or get refused
    mixed_traffic(50, 35, 0);

    // Back to reset capacity, below what is already committed
    write_capacity(CapacityReset);
    mixed_traffic(40, 35, 5);

    settle();
    repeat (400) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_replies.size() == 0) begin
      $display("best_fit_arena_allocator_core_test: done, clean");
    end else begin
      $display("best_fit_arena_allocator_core_test: done, errors");
    end
    $finish;
  end

endmodule
